>>> design/sis_pkg.sv
package sis_pkg;

  // Field widths of the two channels.
  localparam int OP_W    = 2;
  localparam int ELEM_W  = 32;
  localparam int SEED_W  = 64;
  localparam int POS_W   = 6;

  // Default list depth.
  localparam int DEPTH_DEF = 64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_SHUFFLE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // Generator: 64-bit LCG with increment one; the draw is the upper half.
  localparam int            GEN_W    = 64;
  localparam int            HALF_W   = 32;
  localparam logic [63:0]   LCG_MULT = 64'd6364136223846793005;
  localparam logic [31:0]   LCG_M_LO = LCG_MULT[31:0];
  localparam logic [31:0]   LCG_M_HI = LCG_MULT[63:32];

  // Remainder unit: dividend bits retired per cycle.
  localparam int DIV_BITS_PER_CYC = 4;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LL,
    MUL_HL,
    MUL_LH
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_INIT,
    ACC_ADD_HI,
    ACC_COMMIT
  } acc_op_t;

  typedef struct packed {
    logic    append;
    logic    clear;
    logic    load_seed;
    logic    set_i;
    logic    dec_i;
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    div_start;
    logic    swap_rd;
    logic    wr_i;
    logic    wr_j;
    logic    clr_k;
    logic    emit_rd;
    logic    emit_ld;
  } sis_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic i_one;
    logic div_done;
    logic k_last;
    logic out_free;
  } sis_sts_t;

endpackage

>>> design/sis_if.sv
interface sis_in_if;
  import sis_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ELEM_W-1:0] element;
  logic [SEED_W-1:0] seed;

  modport source (output valid, output op, output element, output seed, input ready);
  modport sink   (input valid, input op, input element, input seed, output ready);
endinterface

interface sis_out_if;
  import sis_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element_out;
  logic [POS_W-1:0]  position;
  logic              last;

  modport source (output valid, output element_out, output position, output last,
                  input ready);
  modport sink   (input valid, input element_out, input position, input last,
                  output ready);
endinterface

>>> design/sis_ram.sv
module sis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> design/sis_divmod.sv
module sis_divmod #(
  parameter int DIV_W = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sis_pkg::HALF_W-1:0]  dividend,
  input  logic [DIV_W-1:0]            divisor,
  output logic                        done,
  output logic [DIV_W-1:0]            rem
);
  import sis_pkg::*;

  localparam int STEPS = HALF_W / DIV_BITS_PER_CYC;
  localparam int CYC_W = $clog2(STEPS);
  localparam logic [CYC_W-1:0] LAST_CYC = CYC_W'(STEPS - 1);

  logic              busy_r;
  logic              done_r;
  logic [CYC_W-1:0]  cyc_r;
  logic [HALF_W-1:0] dvd_r;
  logic [DIV_W-1:0]  d_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  rem_nxt;

  // Restoring remainder, several dividend bits per cycle.
  always_comb begin
    logic [DIV_W:0] t;
    rem_nxt = rem_r;
    for (int b = 0; b < DIV_BITS_PER_CYC; b++) begin
      t = {rem_nxt, dvd_r[HALF_W-1-b]};
      if (t >= {1'b0, d_r}) begin
        t = t - {1'b0, d_r};
      end
      rem_nxt = t[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cyc_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cyc_r  <= '0;
        dvd_r  <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= dvd_r << DIV_BITS_PER_CYC;
        rem_r <= rem_nxt;
        cyc_r <= cyc_r + 1'b1;
        if (cyc_r == LAST_CYC) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> design/sis_ctrl.sv
module sis_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [sis_pkg::OP_W-1:0]  in_op,
  output logic                      in_ready,
  input  sis_pkg::sis_sts_t         sts,
  output sis_pkg::sis_cmd_t         cmd
);
  import sis_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GEN0,
    S_GEN1,
    S_GEN2,
    S_GEN3,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SWAP_RD,
    S_SWAP_WI,
    S_SWAP_WJ,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_APPEND: cmd.append = 1'b1;
            OP_CLEAR:  cmd.clear  = 1'b1;
            OP_SHUFFLE: begin
              cmd.load_seed = 1'b1;
              cmd.set_i     = 1'b1;
              cmd.clr_k     = 1'b1;
              if (sts.cnt_zero) begin
                state_nxt = S_IDLE;
              end else if (sts.cnt_one) begin
                state_nxt = S_EMIT_RD;
              end else begin
                state_nxt = S_GEN0;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_GEN0: begin
        cmd.mul_op = MUL_LL;
        state_nxt  = S_GEN1;
      end
      S_GEN1: begin
        cmd.mul_op = MUL_HL;
        cmd.acc_op = ACC_INIT;
        state_nxt  = S_GEN2;
      end
      S_GEN2: begin
        cmd.mul_op = MUL_LH;
        cmd.acc_op = ACC_ADD_HI;
        state_nxt  = S_GEN3;
      end
      S_GEN3: begin
        cmd.acc_op = ACC_COMMIT;
        state_nxt  = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_SWAP_RD;
        end
      end
      S_SWAP_RD: begin
        cmd.swap_rd = 1'b1;
        state_nxt   = S_SWAP_WI;
      end
      S_SWAP_WI: begin
        cmd.wr_i  = 1'b1;
        state_nxt = S_SWAP_WJ;
      end
      S_SWAP_WJ: begin
        cmd.wr_j = 1'b1;
        if (sts.i_one) begin
          state_nxt = S_EMIT_RD;
        end else begin
          cmd.dec_i = 1'b1;
          state_nxt = S_GEN0;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = sts.k_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

>>> design/sis_dp.sv
module sis_dp #(
  parameter int DEPTH = sis_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sis_pkg::sis_cmd_t             cmd,
  output sis_pkg::sis_sts_t             sts,
  input  logic [sis_pkg::ELEM_W-1:0]    in_element,
  input  logic [sis_pkg::SEED_W-1:0]    in_seed,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [sis_pkg::ELEM_W-1:0]    out_element,
  output logic [sis_pkg::POS_W-1:0]     out_position,
  output logic                          out_last
);
  import sis_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  count_r;
  logic [GEN_W-1:0]  gen_r;
  logic [GEN_W-1:0]  prod_r;
  logic [GEN_W-1:0]  acc_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  k_r;
  logic              out_valid_r;
  logic [ELEM_W-1:0] out_element_r;
  logic [POS_W-1:0]  out_position_r;
  logic              out_last_r;

  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic              append_ok;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [ELEM_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr_a;
  logic [ELEM_W-1:0] rdata_a;
  logic [ELEM_W-1:0] rdata_b;
  logic              div_done;
  logic [CNT_W-1:0]  rem;
  logic [IDX_W-1:0]  j_idx;
  logic              k_last;
  logic              out_free;

  assign append_ok = cmd.append && (count_r < DEPTH_C);
  assign j_idx     = rem[IDX_W-1:0];
  assign k_last    = ((CNT_W'(k_r) + 1'b1) == count_r);
  assign out_free  = !out_valid_r || out_ready;

  // Multiplier operand selection for the three partial products.
  always_comb begin
    case (cmd.mul_op)
      MUL_HL: begin
        mul_a = gen_r[GEN_W-1:HALF_W];
        mul_b = LCG_M_LO;
      end
      MUL_LH: begin
        mul_a = gen_r[HALF_W-1:0];
        mul_b = LCG_M_HI;
      end
      default: begin
        mul_a = gen_r[HALF_W-1:0];
        mul_b = LCG_M_LO;
      end
    endcase
  end

  // Store write port: appends and both halves of a swap.
  always_comb begin
    we    = append_ok || cmd.wr_i || cmd.wr_j;
    waddr = j_idx;
    wdata = rdata_a;
    if (append_ok) begin
      waddr = count_r[IDX_W-1:0];
      wdata = in_element;
    end else if (cmd.wr_i) begin
      waddr = i_r;
      wdata = rdata_b;
    end
  end

  assign raddr_a = cmd.swap_rd ? i_r : k_r;

  sis_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (cmd.swap_rd || cmd.emit_rd),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (cmd.swap_rd),
    .raddr_b (j_idx),
    .rdata_b (rdata_b)
  );

  sis_divmod #(
    .DIV_W (CNT_W)
  ) u_divmod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (gen_r[GEN_W-1:HALF_W]),
    .divisor  (CNT_W'(i_r) + 1'b1),
    .done     (div_done),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (append_ok) begin
        count_r <= count_r + 1'b1;
      end

      if (cmd.load_seed) begin
        gen_r <= in_seed;
      end else if (cmd.acc_op == ACC_COMMIT) begin
        gen_r <= {acc_r[GEN_W-1:HALF_W] + prod_r[HALF_W-1:0], acc_r[HALF_W-1:0]};
      end

      if (cmd.emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    case (cmd.acc_op)
      ACC_INIT:   acc_r <= prod_r + GEN_W'(1);
      ACC_ADD_HI: acc_r[GEN_W-1:HALF_W] <= acc_r[GEN_W-1:HALF_W] + prod_r[HALF_W-1:0];
      default:    acc_r <= acc_r;
    endcase

    if (cmd.set_i) begin
      i_r <= IDX_W'(count_r - 1'b1);
    end else if (cmd.dec_i) begin
      i_r <= i_r - 1'b1;
    end

    if (cmd.clr_k) begin
      k_r <= '0;
    end else if (cmd.emit_ld) begin
      k_r <= k_r + 1'b1;
    end

    if (cmd.emit_ld) begin
      out_element_r  <= rdata_a;
      out_position_r <= POS_W'(k_r);
      out_last_r     <= k_last;
    end
  end

  assign sts.cnt_zero = (count_r == '0);
  assign sts.cnt_one  = (count_r == CNT_W'(1));
  assign sts.i_one    = (i_r == IDX_W'(1));
  assign sts.div_done = div_done;
  assign sts.k_last   = k_last;
  assign sts.out_free = out_free;

  assign out_valid    = out_valid_r;
  assign out_element  = out_element_r;
  assign out_position = out_position_r;
  assign out_last     = out_last_r;

endmodule

>>> design/seeded_index_shuffle_core.sv
// Channel   Dir  Handshake      Words carried
// in_ch     in   valid/ready    op, element, seed (one command word)
// out_ch    out  valid/ready    element_out, position, last (one list word)
//
// An append or a clear word leaves the controller idle, so such words may arrive back to back.
// In a shuffle word, each swap steps the generator through GEN0 to GEN3 (one shared
// 32x32 multiplier), runs the remainder unit (four dividend bits a cycle), then reads
// the pair in SWAP_RD and writes it back in SWAP_WI and SWAP_WJ on the single write
// port of the store; each emitted word needs a store read.
// Reset is synchronous and active low; the list is empty and the generator zero.
// A stall on out_ch holds the emit sequence; in_ch is only taken between commands.

module seeded_index_shuffle_core #(
  parameter int DEPTH = sis_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  sis_in_if.sink   in_ch,
  sis_out_if.source out_ch
);
  import sis_pkg::*;

  // Command and status between the sequencer and the datapath.
  sis_cmd_t cmd;
  sis_sts_t sts;

  // The controller walks the shuffle: generator steps, remainder, swap, and
  // finally the emit loop over the stored list.
  sis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the element store, the element count, the generator
  // and the output register which decouples the result side.
  sis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_element   (in_ch.element),
    .in_seed      (in_ch.seed),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_element  (out_ch.element_out),
    .out_position (out_ch.position),
    .out_last     (out_ch.last)
  );

  // A new list word is loaded only when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld |-> sts.out_free)
    else $error("list word loaded while the output register was occupied");

  // A swap read is always followed by the first swap write.
  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap_rd |=> cmd.wr_i)
    else $error("swap read not followed by its first write");

  // The second swap write only ever follows the first.
  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_j |-> $past(cmd.wr_i))
    else $error("second swap write without the first");

  // The remainder cannot be ready in the cycle after it was started.
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done)
    else $error("remainder reported done too early");

endmodule
